[sv/pfrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfrb_pkg;

    localparam int POS_W   = 63;
    localparam int FRAME_W = 48;
    localparam int LEN_W   = 7;
    localparam int DROP_W  = 64;
    localparam int OP_W    = 2;

    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_FRAME_BITS = 48;
    localparam int DEF_MAX_RUN    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RESET = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [POS_W-1:0]   position;
        logic [FRAME_W-1:0] frame_data;
        logic [LEN_W-1:0]   run_length;
    } cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic               frame_valid;
        logic               last;
        logic [POS_W-1:0]   end_mark;
        logic [DROP_W-1:0]  dropped_total;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_CHECK,
        ST_WR_GAP,
        ST_FILL,
        ST_WR_STORE,
        ST_RD_FLOOR,
        ST_RD_LO_START,
        ST_RD_LO_FLOOR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_STATUS
    } state_t;

endpackage

`default_nettype wire

[sv/pfrb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module pfrb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/positioned_frame_ring_buffer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Frame ring of CAPACITY entries addressed by absolute 63-bit frame position.
// A write transaction returns one status response (end mark, drop count);
// a read transaction returns run_length frames (clamped to MAX_RUN, none for
// zero), each flagged valid when it lies in [max(end-CAPACITY, window start,
// reader floor), end); a reset transaction clears the pointers and the drop
// counter but leaves the stored frames; opcode 3 only returns status.
// One transaction is processed at a time. Ring slots are tracked relative to
// the end mark: the block keeps the slot of the end mark, a write lands the
// gap beyond it and a read frame lands (end - position) before it, each a
// short add and one compare-and-subtract. Only positions inside the readable
// window need a real slot, and those all lie within one lap below the end
// mark; a window jump simply restarts the mapping at the current end slot.
// A write is checked and, if it is stored, any gap beyond the end mark is first
// filled with zero frames (up to CAPACITY-1); a read makes one RAM access per
// frame and waits for its registered data. Stalls on rsp hold the block busy.
// Response and request sides are split by an output register, so a new
// request can be taken while the last response is still waiting.
// Frames outside the valid range read back as zero with frame_valid low; no clearing pass after reset.
module positioned_frame_ring_buffer
    import pfrb_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int FRAME_BITS = DEF_FRAME_BITS,
    parameter int MAX_RUN    = DEF_MAX_RUN
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    // slot index width and helper constants
    localparam int SW = $clog2(CAPACITY);
    localparam logic [SW:0]      CAP_EXT   = (SW+1)'(CAPACITY);
    localparam logic [SW-1:0]    SLOT_LAST = SW'(CAPACITY - 1);
    localparam logic [POS_W-1:0] CAP_POS   = POS_W'(CAPACITY);
    localparam logic [DROP_W-1:0] CAP_LIM  = DROP_W'(CAPACITY);
    localparam logic [LEN_W-1:0] RUN_MAX   = LEN_W'(MAX_RUN);

    // control state (reset)
    state_t             state_reg,  state_next;
    logic [POS_W-1:0]   end_reg,    end_next;
    logic [SW-1:0]      eslot_reg,  eslot_next;    // ring slot of the end mark
    logic [POS_W-1:0]   ws_reg,     ws_next;
    logic [POS_W-1:0]   floor_reg,  floor_next;
    logic [DROP_W-1:0]  limit_reg,  limit_next;    // floor + CAPACITY
    logic [DROP_W-1:0]  drop_reg,   drop_next;
    logic               out_valid_reg, out_valid_next;

    // working registers (no reset)
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [FRAME_W-1:0] data_reg,   data_next;
    logic [LEN_W-1:0]   left_reg,   left_next;
    logic [POS_W-1:0]   lo_reg,     lo_next;
    logic [SW-1:0]      slot_reg,   slot_next;     // slot of the write
    logic [SW-1:0]      fslot_reg,  fslot_next;
    logic [SW-1:0]      fleft_reg,  fleft_next;
    logic [DROP_W-1:0]  q_reg,      q_next;
    logic               hit_reg,    hit_next;
    rsp_t               out_reg,    out_next;

    // RAM port signals
    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [FRAME_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [FRAME_BITS-1:0] ram_rdata;

    // gap, write slot and read slot arithmetic
    logic [POS_W-1:0]   gap;
    logic [SW:0]        wsum;
    logic [SW-1:0]      wslot;
    logic [SW:0]        rdist;
    logic [SW:0]        rsum;
    logic [SW-1:0]      rslot;
    logic               out_free;
    logic               cmd_fire;
    logic [LEN_W-1:0]   run_clamped;

    pfrb_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rslot),
        .rdata (ram_rdata)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign run_clamped = (cmd.run_length > RUN_MAX) ? RUN_MAX : cmd.run_length;

    // gap is only used when below CAPACITY, so its low bits hold it
    assign gap   = pos_reg - end_reg;
    assign wsum  = {1'b0, eslot_reg} + {1'b0, gap[SW-1:0]};
    assign wslot = (wsum >= CAP_EXT) ? SW'(wsum - CAP_EXT) : wsum[SW-1:0];

    // inside the window end - q is 1..CAPACITY, so the low bits hold it
    assign rdist = end_reg[SW:0] - q_reg[SW:0];
    assign rsum  = {1'b0, eslot_reg} + CAP_EXT - rdist;
    assign rslot = (rsum >= CAP_EXT) ? SW'(rsum - CAP_EXT) : rsum[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            end_reg       <= '0;
            eslot_reg     <= '0;
            ws_reg        <= '0;
            floor_reg     <= '0;
            limit_reg     <= CAP_LIM;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_reg       <= end_next;
            eslot_reg     <= eslot_next;
            ws_reg        <= ws_next;
            floor_reg     <= floor_next;
            limit_reg     <= limit_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        data_reg  <= data_next;
        left_reg  <= left_next;
        lo_reg    <= lo_next;
        slot_reg  <= slot_next;
        fslot_reg <= fslot_next;
        fleft_reg <= fleft_next;
        q_reg     <= q_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        end_next       = end_reg;
        eslot_next     = eslot_reg;
        ws_next        = ws_reg;
        floor_next     = floor_reg;
        limit_next     = limit_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        pos_next       = pos_reg;
        data_next      = data_reg;
        left_next      = left_reg;
        lo_next        = lo_reg;
        slot_next      = slot_reg;
        fslot_next     = fslot_reg;
        fleft_next     = fleft_reg;
        q_next         = q_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = fslot_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    pos_next  = cmd.position;
                    data_next = cmd.frame_data;
                    left_next = run_clamped;
                    unique case (op_t'(cmd.opcode))
                        OP_WRITE: state_next = ST_WR_CHECK;
                        OP_READ:
                        begin
                            // zero-length read: nothing changes, no response
                            if (cmd.run_length != '0)
                            begin
                                state_next = ST_RD_FLOOR;
                            end
                        end
                        OP_RESET:
                        begin
                            end_next   = '0;
                            ws_next    = '0;
                            floor_next = '0;
                            limit_next = CAP_LIM;
                            drop_next  = '0;
                            state_next = ST_STATUS;
                        end
                        OP_QUERY: state_next = ST_STATUS;
                        default:  state_next = ST_STATUS;
                    endcase
                end
            end

            ST_WR_CHECK:
            begin
                // below the end mark, at or beyond floor + CAPACITY, or topmost
                if ((pos_reg < end_reg) || ({1'b0, pos_reg} >= limit_reg) ||
                    (pos_reg == '1))
                begin
                    drop_next  = drop_reg + 1'b1;
                    state_next = ST_STATUS;
                end
                else
                begin
                    state_next = ST_WR_GAP;
                end
            end

            ST_WR_GAP:
            begin
                if (pos_reg > end_reg)
                begin
                    if (gap >= CAP_POS)
                    begin
                        // a lap or more: restart the window here
                        ws_next    = pos_reg;
                        slot_next  = eslot_reg;
                        state_next = ST_WR_STORE;
                    end
                    else
                    begin
                        fslot_next = eslot_reg;
                        fleft_next = gap[SW-1:0];
                        slot_next  = wslot;
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    slot_next  = eslot_reg;
                    state_next = ST_WR_STORE;
                end
            end

            ST_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fslot_reg;
                fslot_next = (fslot_reg == SLOT_LAST) ? '0 : fslot_reg + 1'b1;
                fleft_next = fleft_reg - 1'b1;
                if (fleft_reg == SW'(1))
                begin
                    state_next = ST_WR_STORE;
                end
            end

            ST_WR_STORE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = FRAME_BITS'(data_reg);
                end_next   = pos_reg + 1'b1;
                eslot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                state_next = ST_STATUS;
            end

            ST_RD_FLOOR:
            begin
                if (pos_reg > floor_reg)
                begin
                    floor_next = pos_reg;
                    limit_next = {1'b0, pos_reg} + CAP_LIM;
                end
                lo_next    = (end_reg >= CAP_POS) ? end_reg - CAP_POS : '0;
                state_next = ST_RD_LO_START;
            end

            ST_RD_LO_START:
            begin
                lo_next    = (lo_reg < ws_reg) ? ws_reg : lo_reg;
                state_next = ST_RD_LO_FLOOR;
            end

            ST_RD_LO_FLOOR:
            begin
                lo_next    = (lo_reg < floor_reg) ? floor_reg : lo_reg;
                q_next     = {1'b0, pos_reg};
                state_next = ST_RD_ADDR;
            end

            ST_RD_ADDR:
            begin
                ram_re     = 1'b1;
                hit_next   = (q_reg >= {1'b0, lo_reg}) && (q_reg < {1'b0, end_reg});
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.frame_out    = hit_reg ? FRAME_W'(ram_rdata) : '0;
                    out_next.frame_valid  = hit_reg;
                    out_next.last         = (left_reg == LEN_W'(1));
                    out_next.end_mark     = end_reg;
                    out_next.dropped_total = drop_reg;
                    q_next    = q_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    state_next = (left_reg == LEN_W'(1)) ? ST_IDLE : ST_RD_ADDR;
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.frame_out    = '0;
                    out_next.frame_valid  = 1'b0;
                    out_next.last         = 1'b1;
                    out_next.end_mark     = end_reg;
                    out_next.dropped_total = drop_reg;
                    state_next            = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire
